FILE: rtl/core/mvna_pkg.sv
// Shared types and codes for the vertex normal accumulator.
package mvna_pkg;

  localparam int IDX_W  = 10;
  localparam int FLD_W  = 16;
  localparam int NORM_W = 16;
  localparam int ACC_W  = 24;

  // Item kinds.
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_TRI   = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]              kind;
    logic [IDX_W-1:0]        vertex_index;
    logic signed [FLD_W-1:0] pos_x;
    logic signed [FLD_W-1:0] pos_y;
    logic signed [FLD_W-1:0] pos_z;
    logic [IDX_W-1:0]        corner_a;
    logic [IDX_W-1:0]        corner_b;
    logic [IDX_W-1:0]        corner_c;
  } item_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
    logic                     zero_length;
  } result_t;

endpackage

FILE: rtl/core/mvna_stream_if.sv
// Valid/ready stream channel carrying one payload type.
interface mvna_stream_if import mvna_pkg::*; #(parameter type T = item_t) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/mesh_vertex_normal_accumulator.sv
// Vertex normal accumulator: position table, per-vertex normal sums, shared unit sequencer.
//
//   channel  dir  payload   transfer when
//   item     in   item_t    item.valid & item.ready
//   result   out  result_t  result.valid & result.ready
//
// One item at a time; item.ready is high only while the sequencer is idle.
// Vertex write: S_WRV, then S_DONE; unused kind or index out of range: straight to S_DONE.
// Read: accumulator read, magnitudes and scaling shifts, then the one-bit-per-cycle root
// and, per component, the one-bit-per-cycle divide loop; a triangle swaps the accumulator read
// for three corner position reads and six products on the shared multiplier, and adds
// a saturating read-modify-write of each of the three corner accumulators.
// Reset clears the sequencer and the result valid flag only; tables are undefined until
// written. A stalled result holds the sequencer in its final state until transferred.
module mesh_vertex_normal_accumulator import mvna_pkg::*; #(
  parameter int VERTEX_DEPTH = 1024,
  parameter int POS_WIDTH    = 16,
  parameter int NORMAL_FRAC  = 14
) (
  input logic           clk,
  input logic           rst,
  mvna_stream_if.sink   item,
  mvna_stream_if.source result
);

  localparam int AW   = $clog2(VERTEX_DEPTH);
  localparam int XW   = (AW > IDX_W) ? AW : IDX_W;
  localparam int PW   = POS_WIDTH;
  localparam int DROP = (POS_WIDTH + 1 > 31) ? POS_WIDTH - 30 : 0;
  localparam int QW   = NORMAL_FRAC + 2;
  localparam int NW   = 31 + NORMAL_FRAC;
  localparam int DCW  = $clog2(QW + 1);
  localparam int AMW  = 3 * ACC_W;

  // Sequencer states.
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_WRV  = 5'd1;
  localparam logic [4:0] S_PRD  = 5'd2;
  localparam logic [4:0] S_PGET = 5'd3;
  localparam logic [4:0] S_MUL  = 5'd4;
  localparam logic [4:0] S_CRS  = 5'd5;
  localparam logic [4:0] S_ARD  = 5'd6;
  localparam logic [4:0] S_AGET = 5'd7;
  localparam logic [4:0] S_MAG  = 5'd8;
  localparam logic [4:0] S_SHF  = 5'd9;
  localparam logic [4:0] S_SQM  = 5'd10;
  localparam logic [4:0] S_SQA  = 5'd11;
  localparam logic [4:0] S_SQRT = 5'd12;
  localparam logic [4:0] S_DIVI = 5'd13;
  localparam logic [4:0] S_DIV  = 5'd14;
  localparam logic [4:0] S_DIVE = 5'd15;
  localparam logic [4:0] S_UPRD = 5'd16;
  localparam logic [4:0] S_UPD  = 5'd17;
  localparam logic [4:0] S_DONE = 5'd18;

  function automatic logic [AW-1:0] to_addr(logic [IDX_W-1:0] x);
    logic [XW-1:0] e;
    e = XW'(x);
    return e[AW-1:0];
  endfunction

  function automatic logic in_rng(logic [IDX_W-1:0] x);
    return 32'(x) < 32'(VERTEX_DEPTH);
  endfunction

  function automatic logic [PW-1:0] to_pos(logic [FLD_W-1:0] f);
    return PW'(f);
  endfunction

  // Edge component, magnitude cut toward zero when the difference is too wide.
  function automatic logic signed [31:0] edge_diff(logic [PW-1:0] p, logic [PW-1:0] q);
    logic [PW:0]   d;
    logic          ng;
    logic [PW:0]   m;
    logic [63:0]   w;
    d  = {p[PW-1], p} - {q[PW-1], q};
    ng = d[PW];
    m  = ng ? (PW+1)'(0) - d : d;
    w  = 64'(m >> DROP);
    return ng ? 32'(0) - w[31:0] : w[31:0];
  endfunction

  function automatic logic [ACC_W-1:0] sat_add(logic [ACC_W-1:0] a, logic [NORM_W-1:0] b);
    logic [ACC_W:0] s;
    s = {a[ACC_W-1], a} + (ACC_W+1)'($signed(b));
    if (!s[ACC_W] && s[ACC_W-1]) return {1'b0, {(ACC_W-1){1'b1}}};
    if (s[ACC_W] && !s[ACC_W-1]) return {1'b1, {(ACC_W-1){1'b0}}};
    return s[ACC_W-1:0];
  endfunction

  function automatic logic [NORM_W-1:0] clamp_q(logic [QW-1:0] q, logic ng);
    logic [31:0] qq;
    logic [31:0] nq;
    qq = 32'(q);
    nq = 32'(0) - qq;
    if (!ng) return (qq > 32'd32767) ? 16'h7fff : qq[15:0];
    return (qq > 32'd32768) ? 16'h8000 : nq[15:0];
  endfunction

  // Sequencer and datapath registers.
  logic [4:0]               state;
  logic [1:0]               kind_r;
  logic [AW-1:0]            vidx;
  logic [AW-1:0]            corner [3];
  logic [3*PW-1:0]          pos_w;
  logic [PW-1:0]            pa [3];
  logic signed [31:0]       e1 [3];
  logic signed [31:0]       e2 [3];
  logic [2:0]               step;
  logic signed [63:0]       prod;
  logic signed [63:0]       vec [3];
  logic [63:0]              mag [3];
  logic                     neg [3];
  logic [63:0]              sum;
  logic [63:0]              rt_n;
  logic [63:0]              rt_r;
  logic [63:0]              rt_bit;
  logic [31:0]              len;
  logic [32:0]              rem;
  logic [QW-1:0]            quo;
  logic [DCW-1:0]           dcnt;
  logic [NORM_W-1:0]        fnorm [3];
  logic                     zero_r;
  logic                     out_valid;
  result_t                  out_data;

  // Memories.
  logic [3*PW-1:0]          pos_mem [VERTEX_DEPTH];
  logic [AMW-1:0]           acc_mem [VERTEX_DEPTH];
  logic [3*PW-1:0]          pos_rd;
  logic [AMW-1:0]           acc_rd;
  logic                     pos_we;
  logic                     acc_we;
  logic [AW-1:0]            pos_raddr;
  logic [AW-1:0]            acc_raddr;
  logic [AW-1:0]            acc_waddr;
  logic [AMW-1:0]           acc_wdata;

  // Combinational helpers.
  logic signed [31:0]       mul_a;
  logic signed [31:0]       mul_b;
  logic [PW-1:0]            rd_p [3];
  logic [ACC_W-1:0]         rd_acc [3];
  logic                     sh_hi;
  logic                     sh_lo;
  logic [63:0]              rt_t;
  logic                     rt_ge;
  logic [63:0]              rt_r_next;
  logic [NW-1:0]            num;
  logic [32:0]              dv_sh;
  logic                     dv_ge;

  assign item.ready   = (state == S_IDLE);
  assign result.valid = out_valid;
  assign result.data  = out_data;

  // Field slices of the memory read words.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rd_p[i]   = pos_rd[i*PW +: PW];
      rd_acc[i] = acc_rd[i*ACC_W +: ACC_W];
    end
  end

  // Memory addressing and write control.
  always_comb begin
    pos_raddr = corner[step[1:0]];
    acc_raddr = (kind_r == KIND_READ) ? vidx : corner[step[1:0]];
    pos_we    = (state == S_WRV);
    acc_we    = (state == S_WRV) || (state == S_UPD);
    acc_waddr = (state == S_WRV) ? vidx : corner[step[1:0]];
    acc_wdata = '0;
    if (state == S_UPD) begin
      for (int i = 0; i < 3; i++) acc_wdata[i*ACC_W +: ACC_W] = sat_add(rd_acc[i], fnorm[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[vidx] <= pos_w;
    pos_rd <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk) begin
    if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
    acc_rd <= acc_mem[acc_raddr];
  end

  // Shared multiplier operand selection: cross product terms or squares.
  always_comb begin
    mul_a = {2'b00, mag[step[1:0]][29:0]};
    mul_b = {2'b00, mag[step[1:0]][29:0]};
    if (state == S_MUL) begin
      case (step)
        3'd0: begin mul_a = e1[1]; mul_b = e2[2]; end
        3'd1: begin mul_a = e1[2]; mul_b = e2[1]; end
        3'd2: begin mul_a = e1[2]; mul_b = e2[0]; end
        3'd3: begin mul_a = e1[0]; mul_b = e2[2]; end
        3'd4: begin mul_a = e1[0]; mul_b = e2[1]; end
        3'd5: begin mul_a = e1[1]; mul_b = e2[0]; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  // Scaling, root and divide step logic.
  always_comb begin
    sh_hi     = |{mag[0][63:30], mag[1][63:30], mag[2][63:30]};
    sh_lo     = ~|{mag[0][63:29], mag[1][63:29], mag[2][63:29]};
    rt_t      = rt_r + rt_bit;
    rt_ge     = (rt_n >= rt_t);
    rt_r_next = rt_ge ? (rt_r >> 1) + rt_bit : (rt_r >> 1);
    num       = {1'b0, mag[step[1:0]][29:0], {NORMAL_FRAC{1'b0}}} + NW'(len >> 1);
    dv_sh     = {rem[31:0], quo[QW-1]};
    dv_ge     = (dv_sh >= {1'b0, len});
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (item.valid) begin
            kind_r    <= item.data.kind;
            vidx      <= to_addr(item.data.vertex_index);
            corner[0] <= to_addr(item.data.corner_a);
            corner[1] <= to_addr(item.data.corner_b);
            corner[2] <= to_addr(item.data.corner_c);
            pos_w     <= {to_pos(item.data.pos_z), to_pos(item.data.pos_y),
                          to_pos(item.data.pos_x)};
            step      <= '0;
            zero_r    <= 1'b0;
            for (int i = 0; i < 3; i++) fnorm[i] <= '0;
            case (item.data.kind)
              KIND_WRITE: state <= in_rng(item.data.vertex_index) ? S_WRV : S_DONE;
              KIND_TRI: begin
                if (in_rng(item.data.corner_a) && in_rng(item.data.corner_b) &&
                    in_rng(item.data.corner_c)) begin
                  state <= S_PRD;
                end else begin
                  zero_r <= 1'b1;
                  state  <= S_DONE;
                end
              end
              KIND_READ: begin
                if (in_rng(item.data.vertex_index)) begin
                  state <= S_ARD;
                end else begin
                  zero_r <= 1'b1;
                  state  <= S_DONE;
                end
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_WRV: state <= S_DONE;
        S_PRD: state <= S_PGET;
        // Corner positions arrive one per read; edges form as they come.
        S_PGET: begin
          for (int i = 0; i < 3; i++) begin
            if (step == 3'd0) pa[i] <= rd_p[i];
            if (step == 3'd1) e1[i] <= edge_diff(rd_p[i], pa[i]);
            if (step == 3'd2) e2[i] <= edge_diff(rd_p[i], pa[i]);
          end
          if (step == 3'd2) begin
            step  <= '0;
            state <= S_MUL;
          end else begin
            step  <= step + 3'd1;
            state <= S_PRD;
          end
        end
        S_MUL: begin
          prod  <= mul_a * mul_b;
          state <= S_CRS;
        end
        // Even terms open a component, odd terms subtract from it.
        S_CRS: begin
          if (!step[0]) vec[step[2:1]] <= prod;
          else vec[step[2:1]] <= vec[step[2:1]] - prod;
          if (step == 3'd5) begin
            step  <= '0;
            state <= S_MAG;
          end else begin
            step  <= step + 3'd1;
            state <= S_MUL;
          end
        end
        S_ARD: state <= S_AGET;
        S_AGET: begin
          for (int i = 0; i < 3; i++) vec[i] <= 64'($signed(rd_acc[i]));
          state <= S_MAG;
        end
        // Magnitudes and signs; a zero vector skips normalization.
        S_MAG: begin
          for (int i = 0; i < 3; i++) begin
            neg[i] <= vec[i][63];
            mag[i] <= vec[i][63] ? 64'(0) - vec[i] : vec[i];
          end
          if (vec[0] == '0 && vec[1] == '0 && vec[2] == '0) begin
            zero_r <= 1'b1;
            state  <= (kind_r == KIND_TRI) ? S_UPRD : S_DONE;
          end else begin
            state <= S_SHF;
          end
        end
        // One binary shift a cycle until the largest magnitude is in [2^29, 2^30).
        S_SHF: begin
          if (sh_hi) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
          end else if (sh_lo) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
          end else begin
            step  <= '0;
            state <= S_SQM;
          end
        end
        S_SQM: begin
          prod  <= mul_a * mul_b;
          state <= S_SQA;
        end
        S_SQA: begin
          sum <= (step == 3'd0) ? $unsigned(prod) : sum + $unsigned(prod);
          if (step == 3'd2) begin
            rt_n   <= sum + $unsigned(prod);
            rt_r   <= '0;
            rt_bit <= 64'd1 << 62;
            state  <= S_SQRT;
          end else begin
            step  <= step + 3'd1;
            state <= S_SQM;
          end
        end
        // Bit-pair square root, one result bit a cycle.
        S_SQRT: begin
          if (rt_ge) rt_n <= rt_n - rt_t;
          rt_r   <= rt_r_next;
          rt_bit <= rt_bit >> 2;
          if (rt_bit[0]) begin
            len   <= rt_r_next[31:0];
            step  <= '0;
            state <= S_DIVI;
          end
        end
        S_DIVI: begin
          rem   <= 33'(num >> QW);
          quo   <= num[QW-1:0];
          dcnt  <= DCW'(QW);
          state <= S_DIV;
        end
        // Restoring divide, one quotient bit a cycle.
        S_DIV: begin
          rem  <= dv_ge ? dv_sh - {1'b0, len} : dv_sh;
          quo  <= {quo[QW-2:0], dv_ge};
          dcnt <= dcnt - DCW'(1);
          if (dcnt == DCW'(1)) state <= S_DIVE;
        end
        S_DIVE: begin
          fnorm[step[1:0]] <= clamp_q(quo, neg[step[1:0]]);
          if (step == 3'd2) begin
            step  <= '0;
            state <= (kind_r == KIND_TRI) ? S_UPRD : S_DONE;
          end else begin
            step  <= step + 3'd1;
            state <= S_DIVI;
          end
        end
        S_UPRD: state <= S_UPD;
        // Saturating read-modify-write of each corner in turn.
        S_UPD: begin
          if (step == 3'd2) begin
            state <= S_DONE;
          end else begin
            step  <= step + 3'd1;
            state <= S_UPRD;
          end
        end
        S_DONE: begin
          if (!out_valid || result.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || result.ready)) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || result.ready)) begin
      out_data.zero_length <= zero_r;
      out_data.normal_x    <= (kind_r == KIND_READ) ? fnorm[0] : '0;
      out_data.normal_y    <= (kind_r == KIND_READ) ? fnorm[1] : '0;
      out_data.normal_z    <= (kind_r == KIND_READ) ? fnorm[2] : '0;
    end
  end

endmodule

FILE: rtl/core/mvna_checker.sv
// Port-level checks for the vertex normal accumulator, bound to the top level.
module mvna_checker import mvna_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input result_t out_data
);

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // The block works on one item at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while busy");

  // A zero-length result carries an all-zero normal.
  a_zero_norm: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.zero_length |->
      out_data.normal_x == '0 && out_data.normal_y == '0 && out_data.normal_z == '0)
    else $error("zero-length result with nonzero normal");

  // A new result appears only from the busy final state.
  a_rise_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while idle");

endmodule

bind mesh_vertex_normal_accumulator mvna_checker u_mvna_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (item.valid),
  .in_ready  (item.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_data  (result.data)
);

FILE: test/mesh_vertex_normal_accumulator_tb.sv
// Self-checking testbench for the mesh vertex normal accumulator.
`timescale 1ns / 1ps

module mesh_vertex_normal_accumulator_tb;
  import mvna_pkg::*;

  localparam int  DEPTH       = 1024;
  localparam int  FRAC        = 14;
  localparam int  SETTLE      = 400;
  localparam int  CYCLE_LIMIT = 3000000;
  localparam longint ACC_HI   = 64'sd8388607;
  localparam longint ACC_LO   = -64'sd8388608;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mvna_stream_if #(.T(item_t))   item_ch ();
  mvna_stream_if #(.T(result_t)) result_ch ();

  mesh_vertex_normal_accumulator uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  // Shadow copy of the vertex table and the normal sums.
  longint   shadow_pos [DEPTH][3];
  longint   shadow_sum [DEPTH][3];
  bit       is_written [DEPTH];
  int       written_list [$];
  result_t  pending_normals [$];

  int  error_count = 0;
  int  cycle_count = 0;
  bit  quiet = 1'b0;
  int  hold_request = 0;
  int  hold_left = 0;
  int  stall_left = 0;
  int  gap_left;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Scale a vector to unit length in Q1.14; an all-zero vector flags zero length.
  function automatic result_t unit_of(longint vx, longint vy, longint vz);
    longint          comp [3];
    longint unsigned mag [3];
    longint unsigned top, total, root, rem, bitv, q;
    result_t         r;
    comp[0] = vx;
    comp[1] = vy;
    comp[2] = vz;
    r = '0;
    top = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = comp[i] < 0 ? -comp[i] : comp[i];
      if (mag[i] > top) top = mag[i];
    end
    if (top == 0) begin
      r.zero_length = 1'b1;
      return r;
    end
    while (top >= (64'd1 << 30)) begin
      top = top >> 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
    end
    while (top < (64'd1 << 29)) begin
      top = top << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    total = 0;
    for (int i = 0; i < 3; i++) total += mag[i] * mag[i];
    // Bitwise integer square root.
    rem  = total;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << FRAC) + root / 2) / root;
      if (comp[i] < 0) begin
        if (q > 32768) q = 32768;
        comp[i] = -longint'(q);
      end else begin
        if (q > 32767) q = 32767;
        comp[i] = longint'(q);
      end
    end
    r.normal_x = comp[0][15:0];
    r.normal_y = comp[1][15:0];
    r.normal_z = comp[2][15:0];
    return r;
  endfunction

  function automatic longint clamp_sum(longint s);
    if (s > ACC_HI) return ACC_HI;
    if (s < ACC_LO) return ACC_LO;
    return s;
  endfunction

  // Update the shadow tables for one accepted item and return its expected result.
  function automatic result_t predict_normal(item_t it);
    result_t r;
    result_t face;
    longint  e1 [3];
    longint  e2 [3];
    int      corner [3];
    r = '0;
    case (it.kind)
      KIND_WRITE: begin
        shadow_pos[it.vertex_index][0] = longint'(it.pos_x);
        shadow_pos[it.vertex_index][1] = longint'(it.pos_y);
        shadow_pos[it.vertex_index][2] = longint'(it.pos_z);
        for (int i = 0; i < 3; i++) shadow_sum[it.vertex_index][i] = 0;
        if (!is_written[it.vertex_index]) begin
          is_written[it.vertex_index] = 1'b1;
          written_list.push_back(int'(it.vertex_index));
        end
      end
      KIND_TRI: begin
        corner[0] = int'(it.corner_a);
        corner[1] = int'(it.corner_b);
        corner[2] = int'(it.corner_c);
        for (int i = 0; i < 3; i++) begin
          e1[i] = shadow_pos[corner[1]][i] - shadow_pos[corner[0]][i];
          e2[i] = shadow_pos[corner[2]][i] - shadow_pos[corner[0]][i];
        end
        face = unit_of(e1[1] * e2[2] - e1[2] * e2[1],
                       e1[2] * e2[0] - e1[0] * e2[2],
                       e1[0] * e2[1] - e1[1] * e2[0]);
        r.zero_length = face.zero_length;
        for (int k = 0; k < 3; k++) begin
          shadow_sum[corner[k]][0] = clamp_sum(shadow_sum[corner[k]][0] + face.normal_x);
          shadow_sum[corner[k]][1] = clamp_sum(shadow_sum[corner[k]][1] + face.normal_y);
          shadow_sum[corner[k]][2] = clamp_sum(shadow_sum[corner[k]][2] + face.normal_z);
        end
      end
      KIND_READ: begin
        r = unit_of(shadow_sum[it.vertex_index][0], shadow_sum[it.vertex_index][1],
                    shadow_sum[it.vertex_index][2]);
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one item until it transfers, then record its expected result.
  task automatic send_item(item_t it);
    item_ch.valid <= 1'b1;
    item_ch.data  <= it;
    do @(posedge clk); while (!(item_ch.valid && item_ch.ready));
    pending_normals.push_back(predict_normal(it));
    if (!quiet && ($urandom_range(0, 3) == 0)) begin
      item_ch.valid <= 1'b0;
      gap_left = $urandom_range(1, 4);
      repeat (gap_left) @(posedge clk);
    end
  endtask

  function automatic item_t noise_item(logic [1:0] kind);
    item_t       it;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    it = raw[$bits(item_t)-1:0];
    it.kind = kind;
    return it;
  endfunction

  task automatic write_vertex(int idx, int x, int y, int z);
    item_t it;
    it = noise_item(KIND_WRITE);
    it.vertex_index = IDX_W'(idx);
    it.pos_x = FLD_W'(x);
    it.pos_y = FLD_W'(y);
    it.pos_z = FLD_W'(z);
    send_item(it);
  endtask

  task automatic add_triangle(int a, int b, int c);
    item_t it;
    it = noise_item(KIND_TRI);
    it.corner_a = IDX_W'(a);
    it.corner_b = IDX_W'(b);
    it.corner_c = IDX_W'(c);
    send_item(it);
  endtask

  task automatic read_normal(int idx);
    item_t it;
    it = noise_item(KIND_READ);
    it.vertex_index = IDX_W'(idx);
    send_item(it);
  endtask

  function automatic int coord_value();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 16);
      1:       return int'($urandom_range(0, 64)) - 32;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  function automatic int pick_written();
    return written_list[$urandom_range(0, written_list.size() - 1)];
  endfunction

  // Extreme positions, each kind, degenerate faces, empty sums and the spare kind.
  task automatic test_directed();
    write_vertex(1020, -32768, -32768, -32768);
    write_vertex(1021, 32767, -32768, -32768);
    write_vertex(1022, -32768, 32767, -32768);
    write_vertex(1023, 32767, 32767, 32767);
    write_vertex(0, 0, 0, 0);
    read_normal(1023);
    add_triangle(1020, 1021, 1022);
    add_triangle(1021, 1023, 1020);
    add_triangle(1020, 1020, 1021);
    add_triangle(0, 1023, 1020);
    add_triangle(1023, 1022, 0);
    read_normal(1020);
    read_normal(1021);
    read_normal(1022);
    read_normal(1023);
    read_normal(0);
    send_item(noise_item(KIND_SPARE));
    write_vertex(1023, 1, 1, 1);
    read_normal(1023);
    add_triangle(1023, 1023, 1023);
    read_normal(1023);
  endtask

  // Drive the sums past the upper saturation limit, then step back down from it.
  task automatic test_saturation();
    write_vertex(1, 0, 0, 0);
    write_vertex(2, 256, 0, 0);
    write_vertex(3, 0, 256, 0);
    for (int i = 0; i < 520; i++) add_triangle(1, 2, 3);
    read_normal(1);
    read_normal(2);
    read_normal(3);
    for (int i = 0; i < 8; i++) add_triangle(3, 2, 1);
    read_normal(1);
  endtask

  // The receiver holds off for a long stretch while items keep coming.
  task automatic test_backpressure();
    hold_request = 300;
    for (int i = 0; i < 12; i++) read_normal(pick_written());
  endtask

  // Mostly triangles and reads over written vertices, mixed with writes and spare items.
  task automatic test_random(int count);
    int sel;
    int a;
    for (int n = 0; n < count; n++) begin
      if (n > count * 4 / 5) quiet = 1'b1;
      sel = $urandom_range(0, 99);
      if (sel < 25 || written_list.size() < 3) begin
        write_vertex($urandom_range(0, DEPTH - 1), coord_value(), coord_value(), coord_value());
      end else if (sel < 65) begin
        a = pick_written();
        if ($urandom_range(0, 9) == 0) add_triangle(a, a, pick_written());
        else add_triangle(a, pick_written(), pick_written());
      end else if (sel < 95) begin
        read_normal(pick_written());
      end else begin
        send_item(noise_item(KIND_SPARE));
      end
    end
  endtask

  // Receiver: random stalls, one long hold, and the result check.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (pending_normals.size() == 0) begin
          $error("unexpected result transfer");
          error_count++;
        end else begin
          result_t want;
          want = pending_normals.pop_front();
          if (result_ch.data.normal_x !== want.normal_x) begin
            $error("normal_x expected %0d got %0d", want.normal_x, result_ch.data.normal_x);
            error_count++;
          end
          if (result_ch.data.normal_y !== want.normal_y) begin
            $error("normal_y expected %0d got %0d", want.normal_y, result_ch.data.normal_y);
            error_count++;
          end
          if (result_ch.data.normal_z !== want.normal_z) begin
            $error("normal_z expected %0d got %0d", want.normal_z, result_ch.data.normal_z);
            error_count++;
          end
          if (result_ch.data.zero_length !== want.zero_length) begin
            $error("zero_length expected %0b got %0b", want.zero_length,
                   result_ch.data.zero_length);
            error_count++;
          end
        end
      end
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (quiet) begin
        result_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("mesh_vertex_normal_accumulator: mismatch");
      $finish;
    end
  end

  initial begin
    item_ch.valid   = 1'b0;
    item_ch.data    = '0;
    result_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_saturation();
    test_backpressure();
    test_random(230);
    item_ch.valid <= 1'b0;
    while (pending_normals.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (error_count == 0) begin
      $display("mesh_vertex_normal_accumulator: match");
    end else begin
      $display("mesh_vertex_normal_accumulator: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/mvna_pkg.sv
rtl/core/mvna_stream_if.sv
rtl/core/mesh_vertex_normal_accumulator.sv
rtl/core/mvna_checker.sv
test/mesh_vertex_normal_accumulator_tb.sv
